// File: hw/rtl/sbp_pkg.sv
// Package for the subband bit packer: queue entry type, register index codes
// and reset values of the band registers.
// No dependencies; imported by the front end, queue, back end and top level.
package sbp_pkg;

    // Fixed field widths of the sample stream
    localparam int SAMPLE_BITS = 16;
    localparam int BAND_BITS   = 2;
    localparam int WIDTH_BITS  = 5;

    // Bands that own width and offset registers
    localparam int NUM_BANDS = 3;

    // Configuration port geometry
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    // Depth of the queue between front and back end (a power of two)
    localparam int QUEUE_DEPTH = 2;

    // Register index codes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_BAND0_WIDTH  = 3'd0,
        REG_BAND1_WIDTH  = 3'd1,
        REG_BAND2_WIDTH  = 3'd2,
        REG_BAND0_OFFSET = 3'd3,
        REG_BAND1_OFFSET = 3'd4,
        REG_BAND2_OFFSET = 3'd5
    } sbp_reg_idx_t;

    // Reset values of the band registers
    localparam logic [WIDTH_BITS-1:0]  BAND0_WIDTH_RST  = 5'd5;
    localparam logic [WIDTH_BITS-1:0]  BAND1_WIDTH_RST  = 5'd5;
    localparam logic [WIDTH_BITS-1:0]  BAND2_WIDTH_RST  = 5'd2;
    localparam logic [SAMPLE_BITS-1:0] BAND0_OFFSET_RST = 16'hFFF0;
    localparam logic [SAMPLE_BITS-1:0] BAND1_OFFSET_RST = 16'hFFF0;
    localparam logic [SAMPLE_BITS-1:0] BAND2_OFFSET_RST = 16'hFFFE;

    // One classified item: masked field bits, their count and the block end
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] bits;
        logic [WIDTH_BITS-1:0]  width;
        logic                   eob;
    } sbp_entry_t;

endpackage

// File: hw/rtl/sbp_front.sv
// Front end of the subband bit packer: holds the band registers and turns
// each accepted sample into a masked bit field with its width.
// Depends on sbp_pkg.
module sbp_front #(
    parameter int WORD_BITS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [sbp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [sbp_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    input  logic                               in_valid,
    input  logic [sbp_pkg::SAMPLE_BITS-1:0]    in_sample,
    input  logic [sbp_pkg::BAND_BITS-1:0]      in_band,
    input  logic                               in_eob,
    input  logic                               q_full,
    output logic                               in_ready,
    output logic                               push,
    output sbp_pkg::sbp_entry_t                push_entry
);
    import sbp_pkg::*;

    // Widest field a sample may contribute
    localparam int LIMIT = (WORD_BITS < SAMPLE_BITS) ? WORD_BITS : SAMPLE_BITS;
    localparam logic [WIDTH_BITS-1:0] LIMIT_W = WIDTH_BITS'(LIMIT);

    logic [WIDTH_BITS-1:0]  width_reg  [NUM_BANDS];
    logic [SAMPLE_BITS-1:0] offset_reg [NUM_BANDS];

    logic [WIDTH_BITS-1:0]  sel_width;
    logic [SAMPLE_BITS-1:0] sel_offset;
    logic                   band_known;
    logic [WIDTH_BITS-1:0]  eff_width;
    logic [SAMPLE_BITS-1:0] diff;
    logic [SAMPLE_BITS-1:0] field_mask;

    // Band registers; writes to unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg[0]  <= BAND0_WIDTH_RST;
            width_reg[1]  <= BAND1_WIDTH_RST;
            width_reg[2]  <= BAND2_WIDTH_RST;
            offset_reg[0] <= BAND0_OFFSET_RST;
            offset_reg[1] <= BAND1_OFFSET_RST;
            offset_reg[2] <= BAND2_OFFSET_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_BAND0_WIDTH:  width_reg[0]  <= cfg_wdata[WIDTH_BITS-1:0];
                REG_BAND1_WIDTH:  width_reg[1]  <= cfg_wdata[WIDTH_BITS-1:0];
                REG_BAND2_WIDTH:  width_reg[2]  <= cfg_wdata[WIDTH_BITS-1:0];
                REG_BAND0_OFFSET: offset_reg[0] <= cfg_wdata[SAMPLE_BITS-1:0];
                REG_BAND1_OFFSET: offset_reg[1] <= cfg_wdata[SAMPLE_BITS-1:0];
                REG_BAND2_OFFSET: offset_reg[2] <= cfg_wdata[SAMPLE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Select the band's registers; a band without registers adds no bits
    always_comb begin
        sel_width  = '0;
        sel_offset = '0;
        case (in_band)
            2'd0: begin
                sel_width  = width_reg[0];
                sel_offset = offset_reg[0];
            end
            2'd1: begin
                sel_width  = width_reg[1];
                sel_offset = offset_reg[1];
            end
            2'd2: begin
                sel_width  = width_reg[2];
                sel_offset = offset_reg[2];
            end
            default: ;
        endcase
    end

    assign band_known = (32'(in_band) < NUM_BANDS);

    // Saturate the width at the field limit
    assign eff_width = !band_known ? '0 :
                       (sel_width > LIMIT_W) ? LIMIT_W : sel_width;

    // Offset removal and masking to the band width; the low bits of the
    // difference do not depend on its sign extension
    assign diff       = in_sample - sel_offset;
    assign field_mask = ~({SAMPLE_BITS{1'b1}} << eff_width);

    assign in_ready         = !q_full;
    assign push             = in_valid && !q_full;
    assign push_entry.bits  = diff & field_mask;
    assign push_entry.width = eff_width;
    assign push_entry.eob   = in_eob;

endmodule

// File: hw/rtl/sbp_queue.sv
// Short queue between the front and back end of the subband bit packer.
// Depends on sbp_pkg for the entry type and depth.
module sbp_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  sbp_pkg::sbp_entry_t push_entry,
    input  logic                pop,
    output logic                full,
    output logic                head_valid,
    output sbp_pkg::sbp_entry_t head_entry
);
    import sbp_pkg::*;

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    sbp_entry_t          slot_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;

    assign full       = (count_reg == CNT_BITS'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers wrap naturally as the depth is a power of two
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Entry storage needs no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: hw/rtl/sbp_back.sv
// Back end of the subband bit packer: appends each queued bit field to the
// pending word and drives the output register with its one-word spill stage.
// Depends on sbp_pkg.
module sbp_back #(
    parameter int WORD_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                head_valid,
    input  sbp_pkg::sbp_entry_t head_entry,
    output logic                pop,
    output logic                out_valid,
    output logic [WORD_BITS-1:0] out_word,
    output logic                out_last,
    input  logic                out_ready
);
    import sbp_pkg::*;

    localparam int FILL_BITS = $clog2(WORD_BITS);
    localparam int TOT_BITS  = FILL_BITS + 1;
    localparam int ACC_BITS  = 2 * WORD_BITS;

    logic [WORD_BITS-1:0] partial_reg;
    logic [FILL_BITS-1:0] fill_reg;
    logic                 out_valid_reg;
    logic [WORD_BITS-1:0] out_word_reg;
    logic                 out_last_reg;
    logic                 spill_valid_reg;
    logic [WORD_BITS-1:0] spill_word_reg;

    logic [ACC_BITS-1:0]  acc;
    logic [TOT_BITS-1:0]  total;
    logic                 filled;
    logic [TOT_BITS-1:0]  remain;
    logic [WORD_BITS-1:0] partial_next;
    logic                 flush;
    logic                 out_free;
    logic                 head_has_word;

    // Append the field above the pending bits
    assign acc    = ACC_BITS'(partial_reg) | (ACC_BITS'(head_entry.bits) << fill_reg);
    assign total  = TOT_BITS'(fill_reg) + TOT_BITS'(head_entry.width);
    assign filled = (total >= TOT_BITS'(WORD_BITS));
    assign remain = filled ? (total - TOT_BITS'(WORD_BITS)) : total;
    assign partial_next = filled ? acc[ACC_BITS-1:WORD_BITS] : acc[WORD_BITS-1:0];

    // A block end emits the pending word unless a full word just closed it
    assign flush = head_entry.eob && !(filled && (remain == '0));

    assign head_has_word = filled || flush;
    assign out_free      = !out_valid_reg || out_ready;

    // Items without output only move the state; others need the output
    // register free and the spill stage empty
    assign pop = head_valid && (!head_has_word || (out_free && !spill_valid_reg));

    // Packing state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg <= '0;
            fill_reg    <= '0;
        end else if (pop) begin
            if (head_entry.eob) begin
                partial_reg <= '0;
                fill_reg    <= '0;
            end else begin
                partial_reg <= partial_next;
                fill_reg    <= remain[FILL_BITS-1:0];
            end
        end
    end

    // Output register and spill stage for the second word of an item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg   <= 1'b0;
            spill_valid_reg <= 1'b0;
        end else begin
            if (out_free && spill_valid_reg) begin
                out_valid_reg   <= 1'b1;
                spill_valid_reg <= 1'b0;
            end else if (pop && head_has_word) begin
                out_valid_reg   <= 1'b1;
                spill_valid_reg <= filled && flush;
            end else if (out_free) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload of the output register and spill stage
    always_ff @(posedge aclk) begin
        if (out_free && spill_valid_reg) begin
            out_word_reg <= spill_word_reg;
            out_last_reg <= 1'b1;
        end else if (pop && head_has_word) begin
            out_word_reg   <= acc[WORD_BITS-1:0];
            out_last_reg   <= !filled || !flush ? head_entry.eob : 1'b0;
            spill_word_reg <= partial_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign out_last  = out_last_reg;

endmodule

// File: hw/rtl/subband_bit_packer_top.sv
// Subband bit packer, top level: front end, queue and back end.
// Depends on sbp_pkg, sbp_front, sbp_queue and sbp_back.
//
// Input channel s_*: one quantized sample per item, s_tdata carries the
// sample, s_tuser the band number, s_tlast marks the end of a block.
// Output channel m_*: packed words, earliest bits lowest, m_tlast on the
// last word of each block. Each block ends with exactly one word marked last.
// Band registers are written through cfg_wr_en, cfg_index and cfg_wdata;
// the user must write them only while the block is idle, which the block
// itself does not enforce; they take effect on the next item. Throughput:
// one item per cycle while m_tready is high and no spill word waits. An
// item that both fills a word and ends a block with bits left over yields
// two words and holds the back end until the second word moves on; the
// two-entry queue lets the front keep accepting. A word reaches m_tvalid
// through the queue register and then the output register. Reset clears
// the pending bits, the queue and the output register and restores the
// register defaults. When the receiver stalls the output word holds, the
// queue fills behind it and s_tready stays low until the word is taken.
module subband_bit_packer_top #(
    parameter int WORD_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write port
    input  logic                                cfg_wr_en,
    input  logic [sbp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [sbp_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
    // Input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [15:0]                         s_tdata,  // [15:0] sample
    input  logic [1:0]                          s_tuser,  // [1:0] band
    input  logic                                s_tlast,  // end_of_block
    // Output stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((WORD_BITS+7)/8)*8-1:0]      m_tdata,  // [WORD_BITS-1:0] packed_word
    output logic                                m_tlast   // last_word
);
    import sbp_pkg::*;

    localparam int TDATA_BITS = ((WORD_BITS + 7) / 8) * 8;

    logic                 push;
    sbp_entry_t           push_entry;
    logic                 q_full;
    logic                 pop;
    logic                 head_valid;
    sbp_entry_t           head_entry;
    logic [WORD_BITS-1:0] out_word;

    // Classify samples into masked bit fields
    sbp_front #(.WORD_BITS(WORD_BITS)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (s_tvalid),
        .in_sample  (s_tdata[SAMPLE_BITS-1:0]),
        .in_band    (s_tuser),
        .in_eob     (s_tlast),
        .q_full     (q_full),
        .in_ready   (s_tready),
        .push       (push),
        .push_entry (push_entry)
    );

    // Decoupling queue
    sbp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    // Word assembly and output
    sbp_back #(.WORD_BITS(WORD_BITS)) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_word   (out_word),
        .out_last   (m_tlast),
        .out_ready  (m_tready)
    );

    assign m_tdata = TDATA_BITS'(out_word);

endmodule

// File: hw/rtl/sbp_checker.sv
// Port-level checker for the subband bit packer, bound to the top level.
// Depends on subband_bit_packer_top for the bind target.
module sbp_checker #(
    parameter int WORD_BITS = 16
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           s_tlast,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [((WORD_BITS+7)/8)*8-1:0] m_tdata,
    input logic                           m_tlast
);

    // Blocks whose end has been accepted but whose last word is not out
    logic [3:0] open_blocks_reg;
    logic       eob_in;
    logic       last_out;

    assign eob_in   = s_tvalid && s_tready && s_tlast;
    assign last_out = m_tvalid && m_tready && m_tlast;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_blocks_reg <= '0;
        end else if (eob_in && !last_out) begin
            open_blocks_reg <= open_blocks_reg + 1'b1;
        end else if (last_out && !eob_in) begin
            open_blocks_reg <= open_blocks_reg - 1'b1;
        end
    end

    // Reset empties the output register and frees the input side
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("output valid or input stall after reset");

    // A stalled word holds
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // A last word only follows an accepted block end
    a_last_has_block: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> open_blocks_reg != '0)
        else $error("last word without a block end");

    // No output appears from nothing
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(open_blocks_reg) != '0 || $past(s_tvalid, 2)
            || $past(m_tvalid, 2) || $past(s_tvalid, 3))
        else $error("output word without an accepted item");

endmodule

bind subband_bit_packer_top sbp_checker #(.WORD_BITS(WORD_BITS)) u_sbp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
